// File: hdl/tsp_pkg.sv
// Shared types and constants for the trapezoidal speed profile block.
package tsp_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_TARGET_POSITION = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED       = 3'd1;
  localparam logic [2:0] REG_SPEED_STEP      = 3'd2;
  localparam logic [2:0] REG_ACCEL_RATE      = 3'd3;
  localparam logic [2:0] REG_TICK_PERIOD     = 3'd4;

  // Reset values of registers and state
  localparam logic signed [31:0] TARGET_RST = 32'sd655360;
  localparam logic [23:0]        MAX_RST    = 24'd327680;
  localparam logic [23:0]        STEP_RST   = 24'd1638;
  localparam logic [23:0]        ACCEL_RST  = 24'd163840;
  localparam logic [15:0]        TICK_RST   = 16'd655;
  localparam logic signed [31:0] POS_RST    = 32'sd655360;

  // Shared multiplier operand and product widths
  localparam int MA_W = 26;
  localparam int MB_W = 18;
  localparam int MP_W = MA_W + MB_W;

  // Width of the braking test accumulators
  localparam int LW = 60;

  typedef struct packed {
    logic signed [31:0] target_position;
    logic [23:0]        max_speed;
    logic [23:0]        speed_step;
    logic [23:0]        accel_rate;
    logic [15:0]        tick_period;
  } cfg_t;

  typedef struct packed {
    logic signed [24:0] speed_command;
    logic               motor_select;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L0,
    ST_L1,
    ST_R0,
    ST_R1,
    ST_RSUM,
    ST_CMP,
    ST_INC,
    ST_POS,
    ST_DONE
  } st_t;

endpackage

// File: hdl/tsp_mul.sv
// Shared signed multiplier with registered product.
module tsp_mul (
  input  logic                          clk,
  input  logic signed [tsp_pkg::MA_W-1:0] op_a,
  input  logic signed [tsp_pkg::MB_W-1:0] op_b,
  output logic signed [tsp_pkg::MP_W-1:0] prod_r
);
  import tsp_pkg::*;

  logic signed [MP_W-1:0] prod_nxt;

  assign prod_nxt = MP_W'(op_a) * MP_W'(op_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: hdl/tsp_core.sv
// Sequencer and datapath: braking test, speed update and position integration.
module tsp_core (
  input  logic          clk,
  input  logic          rst_n,
  input  tsp_pkg::cfg_t cfg,
  input  logic          start,
  input  logic          button,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_ready,
  output tsp_pkg::res_t res
);
  import tsp_pkg::*;

  st_t state_r, state_nxt;

  logic signed [31:0]  pos_r, pos_nxt;
  logic [23:0]         prev_r, prev_nxt;
  logic                dir_r, dir_nxt;
  logic                motor_r, motor_nxt;
  logic signed [32:0]  dist_r, dist_nxt;
  logic signed [LW-1:0] lhs_r, lhs_nxt;
  logic signed [LW-1:0] rhs_r, rhs_nxt;
  logic [23:0]         speed_r, speed_nxt;

  logic signed [MA_W-1:0] op_a;
  logic signed [MB_W-1:0] op_b;
  logic signed [MP_W-1:0] prod_r;

  logic signed [31:0]  pos_base;
  logic [24:0]         sum_up;
  logic [24:0]         speed_pair;
  logic [41:0]         rnd;
  logic [24:0]         inc;
  logic signed [32:0]  pos_sum;
  logic                brake;

  tsp_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign pos_base   = button ? 32'sd0 : pos_r;
  assign sum_up     = {1'b0, prev_r} + {1'b0, cfg.speed_step};
  assign speed_pair = {1'b0, speed_r} + {1'b0, prev_r};
  assign brake      = $signed({lhs_r[LW-2:0], 1'b0}) <= rhs_r;
  // Round half up, Q16.16 increment from Q8.16 x Q0.16 over two
  assign rnd        = {1'b0, prod_r[40:0]} + 42'h10000;
  assign inc        = rnd[41:17];
  assign pos_sum    = {pos_r[31], pos_r} + {8'b0, inc};

  assign idle      = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_DONE);
  assign res.speed_command = dir_r ? -$signed({1'b0, speed_r}) : $signed({1'b0, speed_r});
  assign res.motor_select  = motor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= POS_RST;
      prev_r  <= '0;
      dir_r   <= 1'b0;
      motor_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      dir_r   <= dir_nxt;
      motor_r <= motor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    lhs_r   <= lhs_nxt;
    rhs_r   <= rhs_nxt;
    speed_r <= speed_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    prev_nxt  = prev_r;
    dir_nxt   = dir_r;
    motor_nxt = motor_r;
    dist_nxt  = dist_r;
    lhs_nxt   = lhs_r;
    rhs_nxt   = rhs_r;
    speed_nxt = speed_r;
    op_a      = '0;
    op_b      = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Button: flip sign, swap motor on positive-to-negative, clear position
          if (button) begin
            dir_nxt = ~dir_r;
            pos_nxt = 32'sd0;
            if (!dir_r) begin
              motor_nxt = ~motor_r;
            end
          end
          dist_nxt  = {cfg.target_position[31], cfg.target_position}
                    - {pos_base[31], pos_base};
          state_nxt = ST_L0;
        end
      end
      ST_L0: begin
        op_a      = {2'b0, cfg.accel_rate};
        op_b      = {2'b0, dist_r[15:0]};
        state_nxt = ST_L1;
      end
      ST_L1: begin
        op_a      = {2'b0, cfg.accel_rate};
        op_b      = {dist_r[32], dist_r[32:16]};
        lhs_nxt   = LW'(prod_r);
        state_nxt = ST_R0;
      end
      ST_R0: begin
        op_a      = {2'b0, prev_r};
        op_b      = {2'b0, prev_r[15:0]};
        lhs_nxt   = lhs_r + (LW'(prod_r) <<< 16);
        state_nxt = ST_R1;
      end
      ST_R1: begin
        op_a      = {2'b0, prev_r};
        op_b      = {10'b0, prev_r[23:16]};
        rhs_nxt   = LW'(prod_r);
        state_nxt = ST_RSUM;
      end
      ST_RSUM: begin
        rhs_nxt   = rhs_r + (LW'(prod_r) <<< 16);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (brake) begin
          speed_nxt = (prev_r > cfg.speed_step) ? prev_r - cfg.speed_step : 24'd0;
        end else begin
          speed_nxt = (sum_up > {1'b0, cfg.max_speed}) ? cfg.max_speed : sum_up[23:0];
        end
        state_nxt = ST_INC;
      end
      ST_INC: begin
        op_a      = {1'b0, speed_pair};
        op_b      = {2'b0, cfg.tick_period};
        state_nxt = ST_POS;
      end
      ST_POS: begin
        // Saturate at the positive limit; increment is never negative
        pos_nxt   = (!pos_sum[32] && pos_sum[31]) ? 32'sh7fffffff : pos_sum[31:0];
        prev_nxt  = speed_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/trapezoidal_speed_profile.sv
// Top level: configuration registers, stream channels and output register.
//
// Usage: each word on the in_ channel is one control tick; in_tdata[0] flags
// a button press seen during that tick. Each tick yields exactly one word on
// the out_ channel: the signed Q8.16 speed command in out_tdata[24:0] and the
// motor select in out_tuser[0].
// Configuration registers are written through cfg_valid/cfg_index/cfg_data;
// cfg_ready is always high, and indexes past the last register are dropped.
// After acceptance the sequencer steps through L0, L1, R0, R1, RSUM, CMP,
// INC, POS and DONE. One shared 26x18 multiplier carries the
// braking-distance product, the speed square and the position increment in
// turn; in_tready stays low until the sequencer is back in idle, so a new
// tick is taken only after the previous result has left the sequencer.
// Reset (rst_n low, synchronous): registers take their defaults, position is
// 10.0, speed is zero, direction positive, motor 0, no output word pending.
// Receiver stall: the output register holds the word; the sequencer may take
// the next tick and waits with its result until the register is free.
module trapezoidal_speed_profile (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: [0] button_event
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // out_tdata: [24:0] speed_command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  // out_tuser: [0] motor_select
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tsp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  res_t res;
  res_t out_r;
  logic out_valid_r, out_valid_nxt;
  logic core_idle, res_valid, res_ready;

  assign cfg_ready = 1'b1;
  assign in_tready = core_idle;
  assign res_ready = !out_valid_r || out_tready;

  tsp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_tvalid && core_idle),
    .button    (in_tdata[0]),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_POSITION: cfg_nxt.target_position = cfg_data;
        REG_MAX_SPEED:       cfg_nxt.max_speed       = cfg_data[23:0];
        REG_SPEED_STEP:      cfg_nxt.speed_step      = cfg_data[23:0];
        REG_ACCEL_RATE:      cfg_nxt.accel_rate      = cfg_data[23:0];
        REG_TICK_PERIOD:     cfg_nxt.tick_period     = cfg_data[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_position <= TARGET_RST;
      cfg_r.max_speed       <= MAX_RST;
      cfg_r.speed_step      <= STEP_RST;
      cfg_r.accel_rate      <= ACCEL_RST;
      cfg_r.tick_period     <= TICK_RST;
      out_valid_r           <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result word whenever the slot is free or being emptied
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_r.speed_command};
  assign out_tuser  = out_r.motor_select;

endmodule
